FILE: sv/ept_pkg.sv
// shared types, opcodes and operand addresses of the parabola tracker
`timescale 1ns / 1ps

package ept_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int VW = 48;
  localparam int AW = 6;
  localparam int CFG_IW = 3;
  localparam int MEM_DEPTH = 48;
  localparam int STATE_DEPTH = 12;
  localparam int SW = $clog2(STATE_DEPTH);
  localparam int PCW = 8;

  localparam logic [VW-1:0] LIM_POS = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] LIM_NEG = {1'b1, {(VW-1){1'b0}}};

  localparam logic [CFG_IW-1:0] CFG_DELTA_X = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_Q_Y     = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_Q_X     = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_Q_K     = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_R_Y     = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_R_X     = 3'd5;

  typedef logic [AW-1:0] addr_t;
  typedef logic [PCW-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BRZ,
    OP_END
  } op_t;

  // state entries
  localparam addr_t A_EY  = 6'd0;
  localparam addr_t A_EX  = 6'd1;
  localparam addr_t A_EK  = 6'd2;
  localparam addr_t A_P00 = 6'd3;
  localparam addr_t A_P01 = 6'd4;
  localparam addr_t A_P02 = 6'd5;
  localparam addr_t A_P10 = 6'd6;
  localparam addr_t A_P11 = 6'd7;
  localparam addr_t A_P12 = 6'd8;
  localparam addr_t A_P20 = 6'd9;
  localparam addr_t A_P21 = 6'd10;
  localparam addr_t A_P22 = 6'd11;
  // scratch entries
  localparam addr_t A_XP0 = 6'd12;
  localparam addr_t A_XP1 = 6'd13;
  localparam addr_t A_SQ  = 6'd14;
  localparam addr_t A_KX  = 6'd15;
  localparam addr_t A_F1  = 6'd16;
  localparam addr_t A_M1  = 6'd17;
  localparam addr_t A_M2  = 6'd18;
  localparam addr_t A_T0  = 6'd19;
  localparam addr_t A_T1  = 6'd20;
  localparam addr_t A_T2  = 6'd21;
  localparam addr_t A_PP0 = 6'd22;
  localparam addr_t A_PP1 = 6'd23;
  localparam addr_t A_PP2 = 6'd24;
  localparam addr_t A_PP3 = 6'd25;
  localparam addr_t A_PP4 = 6'd26;
  localparam addr_t A_PP5 = 6'd27;
  localparam addr_t A_PP6 = 6'd28;
  localparam addr_t A_PP7 = 6'd29;
  localparam addr_t A_PP8 = 6'd30;
  localparam addr_t A_S00 = 6'd31;
  localparam addr_t A_S11 = 6'd32;
  localparam addr_t A_DET = 6'd33;
  localparam addr_t A_I00 = 6'd34;
  localparam addr_t A_I01 = 6'd35;
  localparam addr_t A_I10 = 6'd36;
  localparam addr_t A_I11 = 6'd37;
  localparam addr_t A_K00 = 6'd38;
  localparam addr_t A_K01 = 6'd39;
  localparam addr_t A_K10 = 6'd40;
  localparam addr_t A_K11 = 6'd41;
  localparam addr_t A_K20 = 6'd42;
  localparam addr_t A_K21 = 6'd43;
  localparam addr_t A_E0  = 6'd44;
  localparam addr_t A_E1  = 6'd45;
  localparam addr_t A_SL  = 6'd46;
  localparam addr_t A_NEG = 6'd47;
  // fixed sources
  localparam addr_t A_ZERO = 6'd48;
  localparam addr_t A_ONE  = 6'd49;
  localparam addr_t A_MY   = 6'd50;
  localparam addr_t A_MX   = 6'd51;
  localparam addr_t A_DX   = 6'd52;
  localparam addr_t A_QY   = 6'd53;
  localparam addr_t A_QX   = 6'd54;
  localparam addr_t A_QK   = 6'd55;
  localparam addr_t A_RY   = 6'd56;
  localparam addr_t A_RX   = 6'd57;
  // result staging
  localparam addr_t A_OY   = 6'd58;
  localparam addr_t A_OX   = 6'd59;
  localparam addr_t A_OK   = 6'd60;
  localparam addr_t A_OS   = 6'd61;

  typedef struct packed {
    logic            action;
    logic signed [47:0] meas_y;
    logic signed [47:0] meas_x;
  } in_t;

  typedef struct packed {
    logic signed [47:0] est_y;
    logic signed [47:0] est_x;
    logic signed [47:0] est_k;
    logic signed [47:0] slope;
    logic            overflow;
  } out_t;

  typedef struct packed {
    logic  capture;
    logic  rd;
    logic  start;
    logic  set_ovf;
    logic  load_out;
    op_t   op;
    addr_t dst;
    addr_t a;
    addr_t b;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic a_zero;
  } sts_t;

endpackage

FILE: sv/ekf_parabola_tracker_unit.sv
// top level of the three-state parabola tracking kalman filter
`timescale 1ns / 1ps

// Tracks y = k*x^2 with state [y, x, k] in signed fixed point (FRAC_BITS fraction bits,
// 48-bit words, saturating). A transfer with action 0 loads [meas_y, 0, 0] and an identity
// covariance; action 1 runs one predict and update with measurement [meas_y, meas_x].
// Each transfer yields one result with the estimate, the slope 2*x*k and an overflow flag.
// One item is handled at a time by a microprogram on a shared unit: a multiply sums four
// 24x24 partial products plus rounding and a divide yields one quotient bit a cycle.
// A result waiting in the output register does not block the next transfer in;
// configuration writes take effect at once and belong in idle time.

module ekf_parabola_tracker_unit import ept_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [VW-1:0]     cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data
);

  cmd_t cmd;
  sts_t sts;

  ept_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_data.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ept_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a transfer");

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |=> !sts.done)
    else $error("arithmetic unit finished twice in a row");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result loaded without valid");

endmodule

FILE: sv/ept_datapath.sv
// operand store, shared arithmetic unit and result register of the tracker
`timescale 1ns / 1ps

module ept_datapath import ept_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [VW-1:0]     cfg_wdata,
  input  in_t               in_data,
  input  cmd_t              cmd,
  output sts_t              sts,
  output out_t              out_data
);

  localparam int DW = VW + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam int PW = 2 * VW;
  localparam int HW = VW / 2;
  localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);
  localparam logic [CW-1:0] MUL_STEPS = CW'(4);

  typedef struct packed {
    logic          use_alt;
    logic [VW-1:0] v;
  } alt_t;

  logic [VW-1:0] mem [0:MEM_DEPTH-1];
  logic [STATE_DEPTH-1:0] vld_r;
  logic [VW-1:0] dx_r, my_r, mx_r;
  logic [VW-2:0] qy_r, qx_r, qk_r, ry_r, rx_r;
  logic [VW-1:0] rda_r, rdb_r;
  alt_t alt_a_r, alt_b_r, alt_a, alt_b;
  logic [VW-1:0] opa, opb;

  logic          busy_r, ovf_r, neg_r, dz_r;
  op_t           run_op_r;
  addr_t         run_dst_r;
  logic [CW-1:0] cnt_r;
  logic [VW-1:0] ua_r, ub_r;
  logic [PW-1:0] acc_r;
  logic [DW-1:0] dq_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] res_y_r, res_x_r, res_k_r, res_s_r;
  out_t          out_r;

  function automatic logic [VW-1:0] mag(logic [VW-1:0] v);
    return v[VW-1] ? (~v + VW'(1)) : v;
  endfunction

  function automatic alt_t pick(addr_t ad);
    alt_t r;
    r.use_alt = 1'b1;
    r.v = '0;
    case (ad)
      A_ZERO: r.v = '0;
      A_ONE:  r.v = ONE_V;
      A_MY:   r.v = my_r;
      A_MX:   r.v = mx_r;
      A_DX:   r.v = dx_r;
      A_QY:   r.v = {1'b0, qy_r};
      A_QX:   r.v = {1'b0, qx_r};
      A_QK:   r.v = {1'b0, qk_r};
      A_RY:   r.v = {1'b0, ry_r};
      A_RX:   r.v = {1'b0, rx_r};
      default: begin
        if (ad < AW'(STATE_DEPTH)) begin
          r.use_alt = !vld_r[ad[SW-1:0]];
          r.v = (ad == A_P00 || ad == A_P11 || ad == A_P22) ? ONE_V : '0;
        end else begin
          r.use_alt = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  assign alt_a = pick(cmd.a);
  assign alt_b = pick(cmd.b);
  assign opa = alt_a_r.use_alt ? alt_a_r.v : rda_r;
  assign opb = alt_b_r.use_alt ? alt_b_r.v : rdb_r;

  // operand read
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      if (cmd.a < AW'(MEM_DEPTH)) begin
        rda_r <= mem[cmd.a];
      end
      if (cmd.b < AW'(MEM_DEPTH)) begin
        rdb_r <= mem[cmd.b];
      end
      alt_a_r <= alt_a;
      alt_b_r <= alt_b;
    end
  end

  // arithmetic
  logic [VW:0]    sum;
  logic [VW-1:0]  add_val;
  logic           add_sat;
  logic [HW-1:0]  ma, mb;
  logic [VW-1:0]  pprod;
  logic [PW-1:0]  pp_sh;
  logic [PW-1:0]  mq;
  logic [VW-1:0]  mval;
  logic           mover;
  logic [VW:0]    rsh;
  logic           ge;
  logic [VW-1:0]  rnew;
  logic           dover;
  logic [VW-1:0]  dval;
  logic [VW-1:0]  lim;
  logic [VW-1:0]  ua_n, ub_n;
  logic [DW-1:0]  dividend;
  logic           done;
  logic [VW-1:0]  wb_val;
  logic           wb_sat;

  always_comb begin
    if (run_op_r == OP_SUB) begin
      sum = {opa[VW-1], opa} - {opb[VW-1], opb};
    end else begin
      sum = {opa[VW-1], opa} + {opb[VW-1], opb};
    end
    add_sat = sum[VW] != sum[VW-1];
    add_val = add_sat ? (sum[VW] ? LIM_NEG : LIM_POS) : sum[VW-1:0];

    ma = cnt_r[1] ? ua_r[VW-1:HW] : ua_r[HW-1:0];
    mb = cnt_r[0] ? ub_r[VW-1:HW] : ub_r[HW-1:0];
    pprod = ma * mb;
    case (cnt_r[1:0])
      2'd0:    pp_sh = PW'(pprod);
      2'd3:    pp_sh = PW'(pprod) << VW;
      default: pp_sh = PW'(pprod) << HW;
    endcase

    lim = neg_r ? LIM_NEG : LIM_POS;
    mq = (acc_r + RND) >> FRAC_BITS;
    mover = mq > PW'(lim);
    mval = mover ? lim : (neg_r ? (~mq[VW-1:0] + VW'(1)) : mq[VW-1:0]);

    rsh = {rem_r, dq_r[DW-1]};
    ge = rsh >= {1'b0, ub_r};
    rnew = ge ? VW'(rsh - {1'b0, ub_r}) : rsh[VW-1:0];
    dover = dz_r || (dq_r > DW'(lim));
    dval = dz_r ? '0 : (dover ? lim
                             : (neg_r ? (~dq_r[VW-1:0] + VW'(1)) : dq_r[VW-1:0]));

    ua_n = mag(opa);
    ub_n = mag(opb);
    dividend = (DW'(ua_n) << FRAC_BITS) + DW'(ub_n >> 1);

    done = 1'b0;
    wb_val = add_val;
    wb_sat = add_sat;
    case (run_op_r)
      OP_ADD, OP_SUB: begin
        done = busy_r;
      end
      OP_MUL: begin
        done = busy_r && cnt_r == MUL_STEPS;
        wb_val = mval;
        wb_sat = mover;
      end
      OP_DIV: begin
        done = busy_r && cnt_r == CW'(DW);
        wb_val = dval;
        wb_sat = dover;
      end
      default: done = busy_r;
    endcase
  end

  assign sts.done = done;
  assign sts.a_zero = opa == '0;

  // iteration registers, operand store writeback, measurement and result registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      run_dst_r <= cmd.dst;
      neg_r <= opa[VW-1] ^ opb[VW-1];
      ua_r <= ua_n;
      ub_r <= ub_n;
      dz_r <= ub_n == '0;
      acc_r <= '0;
      rem_r <= '0;
      dq_r <= dividend;
      cnt_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (run_op_r == OP_MUL) begin
        acc_r <= acc_r + pp_sh;
      end
      if (run_op_r == OP_DIV) begin
        rem_r <= rnew;
        dq_r <= {dq_r[DW-2:0], ge};
      end
    end
    if (done) begin
      if (run_dst_r < AW'(MEM_DEPTH)) begin
        mem[run_dst_r] <= wb_val;
      end
      case (run_dst_r)
        A_OY:    res_y_r <= wb_val;
        A_OX:    res_x_r <= wb_val;
        A_OK:    res_k_r <= wb_val;
        A_OS:    res_s_r <= wb_val;
        default: ;
      endcase
    end
    if (cmd.capture) begin
      my_r <= in_data.meas_y;
      mx_r <= in_data.meas_x;
    end
    if (cmd.load_out) begin
      out_r <= {res_y_r, res_x_r, res_k_r, res_s_r, ovf_r};
    end
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      run_op_r <= OP_ADD;
      ovf_r <= 1'b0;
      vld_r <= '0;
      dx_r <= ONE_V;
      qy_r <= (VW-1)'(ONE_V);
      qx_r <= (VW-1)'(ONE_V);
      qk_r <= (VW-1)'(ONE_V);
      ry_r <= (VW-1)'(ONE_V);
      rx_r <= (VW-1)'(ONE_V);
    end else begin
      if (cmd.start) begin
        busy_r <= 1'b1;
        run_op_r <= cmd.op;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (cmd.capture) begin
        ovf_r <= 1'b0;
      end else if (cmd.set_ovf || (done && wb_sat)) begin
        ovf_r <= 1'b1;
      end
      if (done && run_dst_r < AW'(STATE_DEPTH)) begin
        vld_r[run_dst_r[SW-1:0]] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DELTA_X: dx_r <= cfg_wdata;
          CFG_Q_Y:     qy_r <= cfg_wdata[VW-2:0];
          CFG_Q_X:     qx_r <= cfg_wdata[VW-2:0];
          CFG_Q_K:     qk_r <= cfg_wdata[VW-2:0];
          CFG_R_Y:     ry_r <= cfg_wdata[VW-2:0];
          CFG_R_X:     rx_r <= cfg_wdata[VW-2:0];
          default: ;
        endcase
      end
    end
  end

  assign out_data = out_r;

endmodule

FILE: sv/ept_ctrl.sv
// sequencer: microprogram of the load and of the predict/update step
`timescale 1ns / 1ps

module ept_ctrl import ept_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_action,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam pc_t PC_STEP = 8'd0;
  localparam pc_t PC_DETZ = 8'd119;
  localparam pc_t PC_LOAD = 8'd137;

  typedef struct packed {
    op_t   op;
    addr_t d;
    addr_t a;
    addr_t b;
  } instr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_WAIT,
    S_DONE
  } state_t;

  function automatic instr_t ins(op_t o, addr_t d, addr_t a, addr_t b);
    instr_t r;
    r.op = o;
    r.d = d;
    r.a = a;
    r.b = b;
    return r;
  endfunction

  function automatic instr_t rom(pc_t pc);
    instr_t r;
    r = ins(OP_END, A_ZERO, A_ZERO, A_ZERO);
    case (pc)
      // predict
      8'd0:   r = ins(OP_ADD, A_XP1, A_EX, A_DX);
      8'd1:   r = ins(OP_MUL, A_SQ, A_XP1, A_XP1);
      8'd2:   r = ins(OP_MUL, A_XP0, A_EK, A_SQ);
      8'd3:   r = ins(OP_MUL, A_KX, A_EK, A_XP1);
      8'd4:   r = ins(OP_ADD, A_F1, A_KX, A_KX);
      8'd5:   r = ins(OP_MUL, A_M1, A_F1, A_P10);
      8'd6:   r = ins(OP_MUL, A_M2, A_SQ, A_P20);
      8'd7:   r = ins(OP_ADD, A_T0, A_M1, A_M2);
      8'd8:   r = ins(OP_MUL, A_M1, A_F1, A_P11);
      8'd9:   r = ins(OP_MUL, A_M2, A_SQ, A_P21);
      8'd10:  r = ins(OP_ADD, A_T1, A_M1, A_M2);
      8'd11:  r = ins(OP_MUL, A_M1, A_F1, A_P12);
      8'd12:  r = ins(OP_MUL, A_M2, A_SQ, A_P22);
      8'd13:  r = ins(OP_ADD, A_T2, A_M1, A_M2);
      8'd14:  r = ins(OP_MUL, A_M1, A_T1, A_F1);
      8'd15:  r = ins(OP_MUL, A_M2, A_T2, A_SQ);
      8'd16:  r = ins(OP_ADD, A_PP0, A_M1, A_M2);
      8'd17:  r = ins(OP_ADD, A_PP1, A_T1, A_ZERO);
      8'd18:  r = ins(OP_ADD, A_PP2, A_T2, A_ZERO);
      8'd19:  r = ins(OP_MUL, A_M1, A_P11, A_F1);
      8'd20:  r = ins(OP_MUL, A_M2, A_P12, A_SQ);
      8'd21:  r = ins(OP_ADD, A_PP3, A_M1, A_M2);
      8'd22:  r = ins(OP_ADD, A_PP4, A_P11, A_ZERO);
      8'd23:  r = ins(OP_ADD, A_PP5, A_P12, A_ZERO);
      8'd24:  r = ins(OP_MUL, A_M1, A_P21, A_F1);
      8'd25:  r = ins(OP_MUL, A_M2, A_P22, A_SQ);
      8'd26:  r = ins(OP_ADD, A_PP6, A_M1, A_M2);
      8'd27:  r = ins(OP_ADD, A_PP7, A_P21, A_ZERO);
      8'd28:  r = ins(OP_ADD, A_PP8, A_P22, A_ZERO);
      8'd29:  r = ins(OP_ADD, A_PP0, A_PP0, A_QY);
      8'd30:  r = ins(OP_ADD, A_PP4, A_PP4, A_QX);
      8'd31:  r = ins(OP_ADD, A_PP8, A_PP8, A_QK);
      // innovation
      8'd32:  r = ins(OP_ADD, A_S00, A_PP0, A_RY);
      8'd33:  r = ins(OP_ADD, A_S11, A_PP4, A_RX);
      8'd34:  r = ins(OP_MUL, A_M1, A_S00, A_S11);
      8'd35:  r = ins(OP_MUL, A_M2, A_PP1, A_PP3);
      8'd36:  r = ins(OP_SUB, A_DET, A_M1, A_M2);
      8'd37:  r = ins(OP_BRZ, A_ZERO, A_DET, A_ZERO);
      8'd38:  r = ins(OP_DIV, A_I00, A_S11, A_DET);
      8'd39:  r = ins(OP_SUB, A_NEG, A_ZERO, A_PP1);
      8'd40:  r = ins(OP_DIV, A_I01, A_NEG, A_DET);
      8'd41:  r = ins(OP_SUB, A_NEG, A_ZERO, A_PP3);
      8'd42:  r = ins(OP_DIV, A_I10, A_NEG, A_DET);
      8'd43:  r = ins(OP_DIV, A_I11, A_S00, A_DET);
      // gain
      8'd44:  r = ins(OP_MUL, A_M1, A_PP0, A_I00);
      8'd45:  r = ins(OP_MUL, A_M2, A_PP1, A_I10);
      8'd46:  r = ins(OP_ADD, A_K00, A_M1, A_M2);
      8'd47:  r = ins(OP_MUL, A_M1, A_PP0, A_I01);
      8'd48:  r = ins(OP_MUL, A_M2, A_PP1, A_I11);
      8'd49:  r = ins(OP_ADD, A_K01, A_M1, A_M2);
      8'd50:  r = ins(OP_MUL, A_M1, A_PP3, A_I00);
      8'd51:  r = ins(OP_MUL, A_M2, A_PP4, A_I10);
      8'd52:  r = ins(OP_ADD, A_K10, A_M1, A_M2);
      8'd53:  r = ins(OP_MUL, A_M1, A_PP3, A_I01);
      8'd54:  r = ins(OP_MUL, A_M2, A_PP4, A_I11);
      8'd55:  r = ins(OP_ADD, A_K11, A_M1, A_M2);
      8'd56:  r = ins(OP_MUL, A_M1, A_PP6, A_I00);
      8'd57:  r = ins(OP_MUL, A_M2, A_PP7, A_I10);
      8'd58:  r = ins(OP_ADD, A_K20, A_M1, A_M2);
      8'd59:  r = ins(OP_MUL, A_M1, A_PP6, A_I01);
      8'd60:  r = ins(OP_MUL, A_M2, A_PP7, A_I11);
      8'd61:  r = ins(OP_ADD, A_K21, A_M1, A_M2);
      // state update
      8'd62:  r = ins(OP_SUB, A_E0, A_MY, A_XP0);
      8'd63:  r = ins(OP_SUB, A_E1, A_MX, A_XP1);
      8'd64:  r = ins(OP_MUL, A_M1, A_K00, A_E0);
      8'd65:  r = ins(OP_ADD, A_M1, A_XP0, A_M1);
      8'd66:  r = ins(OP_MUL, A_M2, A_K01, A_E1);
      8'd67:  r = ins(OP_ADD, A_EY, A_M1, A_M2);
      8'd68:  r = ins(OP_MUL, A_M1, A_K10, A_E0);
      8'd69:  r = ins(OP_ADD, A_M1, A_XP1, A_M1);
      8'd70:  r = ins(OP_MUL, A_M2, A_K11, A_E1);
      8'd71:  r = ins(OP_ADD, A_EX, A_M1, A_M2);
      8'd72:  r = ins(OP_MUL, A_M1, A_K20, A_E0);
      8'd73:  r = ins(OP_ADD, A_M1, A_EK, A_M1);
      8'd74:  r = ins(OP_MUL, A_M2, A_K21, A_E1);
      8'd75:  r = ins(OP_ADD, A_EK, A_M1, A_M2);
      // covariance update
      8'd76:  r = ins(OP_MUL, A_M1, A_K00, A_PP0);
      8'd77:  r = ins(OP_SUB, A_M1, A_PP0, A_M1);
      8'd78:  r = ins(OP_MUL, A_M2, A_K01, A_PP3);
      8'd79:  r = ins(OP_SUB, A_P00, A_M1, A_M2);
      8'd80:  r = ins(OP_MUL, A_M1, A_K00, A_PP1);
      8'd81:  r = ins(OP_SUB, A_M1, A_PP1, A_M1);
      8'd82:  r = ins(OP_MUL, A_M2, A_K01, A_PP4);
      8'd83:  r = ins(OP_SUB, A_P01, A_M1, A_M2);
      8'd84:  r = ins(OP_MUL, A_M1, A_K00, A_PP2);
      8'd85:  r = ins(OP_SUB, A_M1, A_PP2, A_M1);
      8'd86:  r = ins(OP_MUL, A_M2, A_K01, A_PP5);
      8'd87:  r = ins(OP_SUB, A_P02, A_M1, A_M2);
      8'd88:  r = ins(OP_MUL, A_M1, A_K10, A_PP0);
      8'd89:  r = ins(OP_SUB, A_M1, A_PP3, A_M1);
      8'd90:  r = ins(OP_MUL, A_M2, A_K11, A_PP3);
      8'd91:  r = ins(OP_SUB, A_P10, A_M1, A_M2);
      8'd92:  r = ins(OP_MUL, A_M1, A_K10, A_PP1);
      8'd93:  r = ins(OP_SUB, A_M1, A_PP4, A_M1);
      8'd94:  r = ins(OP_MUL, A_M2, A_K11, A_PP4);
      8'd95:  r = ins(OP_SUB, A_P11, A_M1, A_M2);
      8'd96:  r = ins(OP_MUL, A_M1, A_K10, A_PP2);
      8'd97:  r = ins(OP_SUB, A_M1, A_PP5, A_M1);
      8'd98:  r = ins(OP_MUL, A_M2, A_K11, A_PP5);
      8'd99:  r = ins(OP_SUB, A_P12, A_M1, A_M2);
      8'd100: r = ins(OP_MUL, A_M1, A_K20, A_PP0);
      8'd101: r = ins(OP_SUB, A_M1, A_PP6, A_M1);
      8'd102: r = ins(OP_MUL, A_M2, A_K21, A_PP3);
      8'd103: r = ins(OP_SUB, A_P20, A_M1, A_M2);
      8'd104: r = ins(OP_MUL, A_M1, A_K20, A_PP1);
      8'd105: r = ins(OP_SUB, A_M1, A_PP7, A_M1);
      8'd106: r = ins(OP_MUL, A_M2, A_K21, A_PP4);
      8'd107: r = ins(OP_SUB, A_P21, A_M1, A_M2);
      8'd108: r = ins(OP_MUL, A_M1, A_K20, A_PP2);
      8'd109: r = ins(OP_SUB, A_M1, A_PP8, A_M1);
      8'd110: r = ins(OP_MUL, A_M2, A_K21, A_PP5);
      8'd111: r = ins(OP_SUB, A_P22, A_M1, A_M2);
      8'd112: r = ins(OP_MUL, A_SL, A_EX, A_EK);
      8'd113: r = ins(OP_ADD, A_SL, A_SL, A_SL);
      8'd114: r = ins(OP_ADD, A_OY, A_EY, A_ZERO);
      8'd115: r = ins(OP_ADD, A_OX, A_EX, A_ZERO);
      8'd116: r = ins(OP_ADD, A_OK, A_EK, A_ZERO);
      8'd117: r = ins(OP_ADD, A_OS, A_SL, A_ZERO);
      8'd118: r = ins(OP_END, A_ZERO, A_ZERO, A_ZERO);
      // singular innovation: keep the prediction
      8'd119: r = ins(OP_ADD, A_EY, A_XP0, A_ZERO);
      8'd120: r = ins(OP_ADD, A_EX, A_XP1, A_ZERO);
      8'd121: r = ins(OP_ADD, A_P00, A_PP0, A_ZERO);
      8'd122: r = ins(OP_ADD, A_P01, A_PP1, A_ZERO);
      8'd123: r = ins(OP_ADD, A_P02, A_PP2, A_ZERO);
      8'd124: r = ins(OP_ADD, A_P10, A_PP3, A_ZERO);
      8'd125: r = ins(OP_ADD, A_P11, A_PP4, A_ZERO);
      8'd126: r = ins(OP_ADD, A_P12, A_PP5, A_ZERO);
      8'd127: r = ins(OP_ADD, A_P20, A_PP6, A_ZERO);
      8'd128: r = ins(OP_ADD, A_P21, A_PP7, A_ZERO);
      8'd129: r = ins(OP_ADD, A_P22, A_PP8, A_ZERO);
      8'd130: r = ins(OP_MUL, A_SL, A_EX, A_EK);
      8'd131: r = ins(OP_ADD, A_SL, A_SL, A_SL);
      8'd132: r = ins(OP_ADD, A_OY, A_EY, A_ZERO);
      8'd133: r = ins(OP_ADD, A_OX, A_EX, A_ZERO);
      8'd134: r = ins(OP_ADD, A_OK, A_EK, A_ZERO);
      8'd135: r = ins(OP_ADD, A_OS, A_SL, A_ZERO);
      8'd136: r = ins(OP_END, A_ZERO, A_ZERO, A_ZERO);
      // load
      8'd137: r = ins(OP_ADD, A_EY, A_MY, A_ZERO);
      8'd138: r = ins(OP_ADD, A_EX, A_ZERO, A_ZERO);
      8'd139: r = ins(OP_ADD, A_EK, A_ZERO, A_ZERO);
      8'd140: r = ins(OP_ADD, A_P00, A_ONE, A_ZERO);
      8'd141: r = ins(OP_ADD, A_P01, A_ZERO, A_ZERO);
      8'd142: r = ins(OP_ADD, A_P02, A_ZERO, A_ZERO);
      8'd143: r = ins(OP_ADD, A_P10, A_ZERO, A_ZERO);
      8'd144: r = ins(OP_ADD, A_P11, A_ONE, A_ZERO);
      8'd145: r = ins(OP_ADD, A_P12, A_ZERO, A_ZERO);
      8'd146: r = ins(OP_ADD, A_P20, A_ZERO, A_ZERO);
      8'd147: r = ins(OP_ADD, A_P21, A_ZERO, A_ZERO);
      8'd148: r = ins(OP_ADD, A_P22, A_ONE, A_ZERO);
      8'd149: r = ins(OP_ADD, A_OY, A_EY, A_ZERO);
      8'd150: r = ins(OP_ADD, A_OX, A_ZERO, A_ZERO);
      8'd151: r = ins(OP_ADD, A_OK, A_ZERO, A_ZERO);
      8'd152: r = ins(OP_ADD, A_OS, A_ZERO, A_ZERO);
      default: r = ins(OP_END, A_ZERO, A_ZERO, A_ZERO);
    endcase
    return r;
  endfunction

  state_t state_r, state_nxt;
  pc_t    pc_r, pc_nxt;
  logic   out_valid_r, out_valid_nxt;
  instr_t ir;
  logic   is_alu;

  assign ir = rom(pc_r);
  assign is_alu = ir.op == OP_ADD || ir.op == OP_SUB || ir.op == OP_MUL || ir.op == OP_DIV;
  assign in_ready = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.capture  = state_r == S_IDLE && in_valid;
    cmd.rd       = state_r == S_READ;
    cmd.start    = state_r == S_EXEC && is_alu;
    cmd.set_ovf  = state_r == S_EXEC && ir.op == OP_BRZ && sts.a_zero;
    cmd.load_out = state_r == S_DONE && (!out_valid_r || out_ready);
    cmd.op  = ir.op;
    cmd.dst = ir.d;
    cmd.a   = ir.a;
    cmd.b   = ir.b;

    state_nxt = state_r;
    pc_nxt = pc_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pc_nxt = in_action ? PC_STEP : PC_LOAD;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        case (ir.op)
          OP_END: state_nxt = S_DONE;
          OP_BRZ: begin
            pc_nxt = sts.a_zero ? PC_DETZ : pc_r + PCW'(1);
            state_nxt = S_READ;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_nxt = S_WAIT;
          default: state_nxt = S_DONE;
        endcase
      end
      S_WAIT: begin
        if (sts.done) begin
          pc_nxt = pc_r + PCW'(1);
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (cmd.load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r <= PC_STEP;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: tb/ekf_parabola_tracker_unit_tb.sv
// testbench of the parabola tracking kalman filter with a bit-exact software predictor
`timescale 1ns / 1ps

module ekf_parabola_tracker_unit_tb;
  import ept_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint MAXV = 64'sh7FFFFFFFFFFF;
  localparam longint MINV = -MAXV - 1;
  localparam longint ONE = 64'sd1 << FB;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = CFG_DELTA_X;
  logic [VW-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;

  ekf_parabola_tracker_unit dut (.*);

  always #2 clk = ~clk;

  // filter state held by the predictor
  longint est[3];
  longint cov[9];
  longint dx_r, qy_r, qx_r, qk_r, ry_r, rx_r;
  bit sat;

  out_t est_queue[$];
  int fails = 0;
  int n_loads = 0, n_updates = 0, n_sat = 0, n_results = 0;
  bit in_burst = 0, out_burst = 0;
  bit in_fire, out_fire;
  int idle_cycles = 0;

  function automatic longint clampv(longint s);
    if (s > MAXV) begin
      sat = 1;
      return MAXV;
    end
    if (s < MINV) begin
      sat = 1;
      return MINV;
    end
    return s;
  endfunction

  function automatic longint sadd(longint a, longint b);
    return clampv(a + b);
  endfunction

  function automatic longint ssub(longint a, longint b);
    return clampv(a - b);
  endfunction

  function automatic longint pack_mag(bit neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (m > lim) begin
      sat = 1;
      return neg ? MINV : MAXV;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint fmul(longint a, longint b);
    logic [127:0] p;
    logic [63:0] ua, ub;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (FB - 1))) >> FB;
    return pack_mag((a < 0) != (b < 0), p);
  endfunction

  function automatic longint fdiv(longint num, longint den);
    logic [127:0] n, q;
    logic [63:0] un, ud;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    if (ud == 0) begin
      sat = 1;
      return 0;
    end
    n = ({64'd0, un} << FB) + {64'd0, ud >> 1};
    q = n / {64'd0, ud};
    return pack_mag((num < 0) != (den < 0), q);
  endfunction

  function automatic void mat3(input longint a[9], input longint b[9], output longint c[9],
                               input bit bt);
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int m = 0; m < 3; m++)
          acc = sadd(acc, fmul(a[i*3+m], bt ? b[j*3+m] : b[m*3+j]));
        c[i*3+j] = acc;
      end
  endfunction

  function automatic void reset_filter();
    est = '{0, 0, 0};
    cov = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    dx_r = ONE; qy_r = ONE; qx_r = ONE; qk_r = ONE; ry_r = ONE; rx_r = ONE;
  endfunction

  function automatic void write_reg(logic [CFG_IW-1:0] idx, logic [VW-1:0] v);
    longint u;
    u = longint'({17'd0, v[46:0]});
    case (idx)
      CFG_DELTA_X: dx_r = longint'(signed'(v));
      CFG_Q_Y: qy_r = u;
      CFG_Q_X: qx_r = u;
      CFG_Q_K: qk_r = u;
      CFG_R_Y: ry_r = u;
      CFG_R_X: rx_r = u;
      default: ;
    endcase
  endfunction

  function automatic out_t track_step(in_t it);
    longint xp[3], f[9], t[9], pp[9], np[9], k0[3], k1[3];
    longint s00, s01, s10, s11, det, i00, i01, i10, i11, e0, e1, kx, sq, slope;
    out_t r;
    slope = 0;
    sat = 0;
    if (!it.action) begin
      est = '{longint'(it.meas_y), 0, 0};
      cov = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
      n_loads++;
    end else begin
      n_updates++;
      xp[1] = sadd(est[1], dx_r);
      xp[2] = est[2];
      sq = fmul(xp[1], xp[1]);
      xp[0] = fmul(xp[2], sq);
      kx = fmul(xp[2], xp[1]);
      f = '{0, sadd(kx, kx), sq, 0, ONE, 0, 0, 0, ONE};
      mat3(f, cov, t, 0);
      mat3(t, f, pp, 1);
      pp[0] = sadd(pp[0], qy_r);
      pp[4] = sadd(pp[4], qx_r);
      pp[8] = sadd(pp[8], qk_r);
      s00 = sadd(pp[0], ry_r);
      s01 = pp[1];
      s10 = pp[3];
      s11 = sadd(pp[4], rx_r);
      det = ssub(fmul(s00, s11), fmul(s01, s10));
      if (det == 0) begin
        sat = 1;
        est = xp;
        cov = pp;
      end else begin
        i00 = fdiv(s11, det);
        i01 = fdiv(ssub(0, s01), det);
        i10 = fdiv(ssub(0, s10), det);
        i11 = fdiv(s00, det);
        for (int i = 0; i < 3; i++) begin
          k0[i] = sadd(fmul(pp[i*3], i00), fmul(pp[i*3+1], i10));
          k1[i] = sadd(fmul(pp[i*3], i01), fmul(pp[i*3+1], i11));
        end
        e0 = ssub(longint'(it.meas_y), xp[0]);
        e1 = ssub(longint'(it.meas_x), xp[1]);
        for (int i = 0; i < 3; i++)
          est[i] = sadd(sadd(xp[i], fmul(k0[i], e0)), fmul(k1[i], e1));
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            np[i*3+j] = ssub(ssub(pp[i*3+j], fmul(k0[i], pp[j])), fmul(k1[i], pp[3+j]));
        cov = np;
      end
      slope = fmul(est[1], est[2]);
      slope = sadd(slope, slope);
    end
    if (sat) n_sat++;
    r.est_y = est[0][47:0];
    r.est_x = est[1][47:0];
    r.est_k = est[2][47:0];
    r.slope = slope[47:0];
    r.overflow = sat;
    return r;
  endfunction

  // handshake sampling between edges; tb drives only at rising edges
  always @(negedge clk) begin
    in_fire = in_valid && in_ready;
    out_fire = out_valid && out_ready;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire || out_fire) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result checking
  always @(negedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (est_queue.size() == 0) begin
        fails++;
        $display("%0t unexpected result %h", $time, out_data);
      end else begin
        exp_r = est_queue.pop_front();
        if (out_data.est_y !== exp_r.est_y)
          $display("%0t est_y exp %h got %h", $time, exp_r.est_y, out_data.est_y);
        if (out_data.est_x !== exp_r.est_x)
          $display("%0t est_x exp %h got %h", $time, exp_r.est_x, out_data.est_x);
        if (out_data.est_k !== exp_r.est_k)
          $display("%0t est_k exp %h got %h", $time, exp_r.est_k, out_data.est_k);
        if (out_data.slope !== exp_r.slope)
          $display("%0t slope exp %h got %h", $time, exp_r.slope, out_data.slope);
        if (out_data.overflow !== exp_r.overflow)
          $display("%0t overflow exp %b got %b", $time, exp_r.overflow, out_data.overflow);
        if (out_data !== exp_r) fails++;
      end
    end
  end

  // result side backpressure
  initial begin
    int w;
    bit f;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      w = out_burst ? 0 : $urandom_range(0, 17);
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1;
      do begin
        @(negedge clk);
        f = out_valid;
        @(posedge clk);
      end while (!f);
    end
  end

  task automatic send_item(bit act, logic [47:0] my, logic [47:0] mx);
    int w;
    bit f;
    in_t it;
    w = in_burst ? 0 : $urandom_range(0, 17);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    it.action = act;
    it.meas_y = my;
    it.meas_x = mx;
    in_valid <= 1;
    in_data <= it;
    do begin
      @(negedge clk);
      f = in_ready;
      @(posedge clk);
    end while (!f);
    est_queue.push_back(track_step(it));
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 0;
    @(posedge clk);
    in_valid <= 0;
    while (est_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IW-1:0] idx, logic [VW-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic set_all(logic [47:0] dx, logic [47:0] qy, logic [47:0] qx,
                         logic [47:0] qk, logic [47:0] ry, logic [47:0] rx);
    drain();
    set_reg(CFG_DELTA_X, dx);
    set_reg(CFG_Q_Y, qy);
    set_reg(CFG_Q_X, qx);
    set_reg(CFG_Q_K, qk);
    set_reg(CFG_R_Y, ry);
    set_reg(CFG_R_X, rx);
    @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // mostly values of modest size, sometimes anything at all
  function automatic logic [47:0] rand_val();
    longint v;
    if ($urandom_range(0, 9) == 0) return rand48();
    v = longint'($urandom_range(0, 32'hFFFFFFFF)) >> $urandom_range(0, 28);
    v = v >>> $urandom_range(0, 4);
    return $urandom_range(0, 1) ? v[47:0] : -v[47:0];
  endfunction

  function automatic logic [47:0] rand_cfg_mag();
    case ($urandom_range(0, 3))
      0: return rand48() >> 1;
      1: return 48'(ONE) >> $urandom_range(0, 20);
      default: return 48'($urandom_range(1, 32'hFFFFFF)) << $urandom_range(0, 8);
    endcase
  endfunction

  task automatic test_default_tracking();
    send_item(0, 48'(3 * ONE), 48'(ONE));
    for (int i = 1; i <= 6; i++)
      send_item(1, 48'(i * i * ONE), 48'(i * ONE));
  endtask

  task automatic test_field_extremes();
    send_item(0, 48'(MAXV), 48'(MINV));
    send_item(1, 48'(MAXV), 48'(MAXV));
    send_item(1, 48'(MINV), 48'(MINV));
    send_item(0, 48'(MINV), 48'(MAXV));
    send_item(1, 48'hFFFFFFFFFFFF, 48'd0);
    send_item(1, 48'd0, 48'hFFFFFFFFFFFF);
  endtask

  task automatic test_singular_innovation();
    set_all(48'd0, 48'd0, 48'd0, 48'(ONE), 48'd0, 48'd0);
    send_item(0, 48'(5 * ONE), 48'd0);
    send_item(1, 48'(2 * ONE), 48'(ONE));
    send_item(1, 48'd7, 48'd9);
  endtask

  task automatic test_register_extremes();
    set_all(48'(MAXV), 48'(MAXV), 48'(MAXV), 48'(MAXV), 48'(MAXV), 48'(MAXV));
    send_item(0, 48'(ONE), 48'd0);
    send_item(1, rand48(), rand48());
    set_all(48'(MINV), 48'd0, 48'd0, 48'd0, 48'(MAXV), 48'd1);
    send_item(1, rand48(), rand48());
    send_item(0, 48'd0, 48'd0);
    send_item(1, 48'(ONE), 48'(MINV));
    // out of range indexes must leave the registers alone
    drain();
    set_reg(3'd6, 48'hFFFFFFFFFFFF);
    set_reg(3'd7, 48'h000000000000);
    send_item(1, 48'(ONE), 48'(ONE));
  endtask

  task automatic test_random_sequences(int total);
    int phase_len, left;
    left = total;
    while (left > 0) begin
      case ($urandom_range(0, 3))
        0: set_all(48'(ONE), 48'(ONE), 48'(ONE), 48'(ONE), 48'(ONE), 48'(ONE));
        1: set_all(rand48(), rand48(), rand48(), rand48(), rand48(), rand48());
        default: set_all(rand_val(), rand_cfg_mag(), rand_cfg_mag(), rand_cfg_mag(),
                         rand_cfg_mag(), rand_cfg_mag());
      endcase
      in_burst = $urandom_range(0, 3) == 0;
      out_burst = $urandom_range(0, 3) == 0;
      phase_len = $urandom_range(150, 350);
      for (int i = 0; i < phase_len && left > 0; i++, left--)
        send_item($urandom_range(0, 15) != 0, rand_val(), rand_val());
    end
    in_burst = 0;
    out_burst = 0;
  endtask

  initial begin
    reset_filter();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_default_tracking();
    test_field_extremes();
    test_singular_innovation();
    test_register_extremes();
    test_random_sequences(1880);
    drain();
    repeat (1000) @(posedge clk);
    $display("run: %0d loads, %0d updates, %0d results checked",
             n_loads, n_updates, n_results);
    $display("run: %0d saturated or singular steps, %0d mismatches", n_sat, fails);
    if (fails == 0 && est_queue.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
sv/ept_pkg.sv
sv/ept_datapath.sv
sv/ept_ctrl.sv
sv/ekf_parabola_tracker_unit.sv
tb/ekf_parabola_tracker_unit_tb.sv
